// ===== rtl/tab_pkg.sv =====
// shared types, codes and sizes of the timed address blocklist
`default_nettype none

package tab_pkg;

  localparam int CAP   = 64;
  localparam int CNT_W = $clog2(CAP + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP
  } state_t;

  localparam logic [1:0] FN_CHECK = 2'd0;
  localparam logic [1:0] FN_AUTO  = 2'd1;
  localparam logic [1:0] FN_SWEEP = 2'd2;
  localparam logic [1:0] FN_NONE  = 2'd3;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_AUTO    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  localparam logic [2:0] ST_ADDED  = 3'd0;
  localparam logic [2:0] ST_LISTED = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ALLOW  = 3'd3;
  localparam logic [2:0] ST_NOCHG  = 3'd4;

  localparam logic [2:0] CFG_DURATION  = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_ALLOW_A   = 3'd2;
  localparam logic [2:0] CFG_ALLOW_B   = 3'd3;
  localparam logic [2:0] CFG_ALLOW_C   = 3'd4;

  localparam logic [31:0] RST_DURATION  = 32'd300;
  localparam logic [15:0] RST_THRESHOLD = 16'd768;
  localparam logic [31:0] RST_ALLOW_A   = 32'hC0A8_0101;
  localparam logic [31:0] RST_ALLOW_B   = 32'h0A00_0001;
  localparam logic [31:0] RST_ALLOW_C   = 32'h7F00_0001;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] since;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tab_cell.sv =====
// one cell of the entry chain: holds an address and its time of entry
`default_nettype none

module tab_cell
  import tab_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    nb,
  input  wire entry_t    ld,
  output entry_t         q
);

  entry_t q_r;
  entry_t q_nxt;

  always_comb begin
    priority if (ctl.load) begin
      q_nxt = ld;
    end else if (ctl.shift) begin
      q_nxt = nb;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/timed_address_blocklist_top.sv =====
// top level of the timed address blocklist: control, registers and cell chain
`default_nettype none

// Accepts a command when start is high and busy is low. Entries sit in a chain
// of 64 cells in insertion order and move one cell towards the head each
// cycle of a pass; the head entry is examined and written back at the tail
// unless a sweep drops it. A packet check or auto-block makes one pass over the
// listed entries, then gives the verdict as one result. A sweep makes one pass
// as well and gives one result per removed entry, or one
// "found nothing" result; last marks the final beat. Each result beat is shown
// for one cycle with out_valid and cannot be held off. The configuration port
// is always ready; write it only while busy is low and no results are pending.

module timed_address_blocklist_top
  import tab_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic [31:0]       in_src_addr,
  input  wire logic [15:0]       in_syn_ack_ratio,
  input  wire logic [31:0]       in_now_time,
  output logic                   out_valid,
  output logic [1:0]             out_kind,
  output logic                   out_drop,
  output logic [31:0]            out_entry_addr_out,
  output logic [2:0]             out_status,
  output logic [6:0]             out_list_count,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0] duration_r, allow_a_r, allow_b_r, allow_c_r;
  logic [15:0] thresh_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             hit_r, hit_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [31:0]      pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic [1:0]  func_r;
  logic [31:0] addr_r, now_r;
  logic [15:0] ratio_r;
  logic        allow_r;

  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic        odrop_r, odrop_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic        olast_r, olast_nxt;

  entry_t           cell_q [CAP];
  cell_ctl_t        ctl    [CAP];
  entry_t           head;
  entry_t           ld_data;
  logic             shift_all, ld_en;
  logic [CNT_W-1:0] ld_idx;
  logic             accept;
  logic             full, expired, add;
  logic [31:0]      age;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign head      = cell_q[0];
  assign full      = (cnt_r >= CNT_W'(CAP));
  assign age       = now_r - head.since;
  assign expired   = (age > duration_r);

  // cell chain
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    entry_t nb;
    if (g == CAP - 1) begin : g_tail
      assign nb = cell_q[g];
    end else begin : g_mid
      assign nb = cell_q[g+1];
    end
    assign ctl[g].shift = shift_all;
    assign ctl[g].load  = ld_en && (ld_idx == CNT_W'(g));
    tab_cell u_cell (
      .clk (clk),
      .ctl (ctl[g]),
      .nb  (nb),
      .ld  (ld_data),
      .q   (cell_q[g])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= RST_DURATION;
      thresh_r   <= RST_THRESHOLD;
      allow_a_r  <= RST_ALLOW_A;
      allow_b_r  <= RST_ALLOW_B;
      allow_c_r  <= RST_ALLOW_C;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DURATION:  duration_r <= cfg_data;
        CFG_THRESHOLD: thresh_r   <= cfg_data[15:0];
        CFG_ALLOW_A:   allow_a_r  <= cfg_data;
        CFG_ALLOW_B:   allow_b_r  <= cfg_data;
        CFG_ALLOW_C:   allow_c_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      addr_r  <= in_src_addr;
      ratio_r <= in_syn_ack_ratio;
      now_r   <= in_now_time;
      allow_r <= (in_src_addr == allow_a_r) || (in_src_addr == allow_b_r) ||
                 (in_src_addr == allow_c_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func != FN_NONE) begin
          state_nxt = (in_func == FN_SWEEP) ? ST_SWEEP : ST_SCAN;
        end
      end
      ST_SCAN, ST_SWEEP: begin
        if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    hit_nxt       = hit_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    pend_cnt_nxt  = pend_cnt_r;
    ov_nxt        = 1'b0;
    okind_nxt     = okind_r;
    odrop_nxt     = odrop_r;
    oaddr_nxt     = oaddr_r;
    ostat_nxt     = ostat_r;
    ocnt_nxt      = ocnt_r;
    olast_nxt     = olast_r;
    shift_all     = 1'b0;
    ld_en         = 1'b0;
    ld_idx        = cnt_r - CNT_W'(1);
    ld_data       = head;
    add           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rem_nxt    = cnt_r;
          hit_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rem_r != '0) begin
          shift_all = 1'b1;
          ld_en     = 1'b1;
          rem_nxt   = rem_r - CNT_W'(1);
          hit_nxt   = hit_r || (head.addr == addr_r);
        end else begin
          odrop_nxt = 1'b0;
          ostat_nxt = ST_NOCHG;
          if (func_r == FN_CHECK) begin
            priority if (allow_r) begin
              ostat_nxt = ST_ALLOW;
            end else if (hit_r) begin
              odrop_nxt = 1'b1;
              ostat_nxt = ST_LISTED;
            end else if (ratio_r > thresh_r) begin
              odrop_nxt = 1'b1;
              if (full) begin
                ostat_nxt = ST_FULL;
              end else begin
                ostat_nxt = ST_ADDED;
                add       = 1'b1;
              end
            end else begin
              ostat_nxt = ST_NOCHG;
            end
          end else begin
            priority if (allow_r) begin
              ostat_nxt = ST_ALLOW;
            end else if (full) begin
              ostat_nxt = ST_FULL;
            end else if (hit_r) begin
              ostat_nxt = ST_LISTED;
            end else begin
              ostat_nxt = ST_ADDED;
              add       = 1'b1;
            end
          end
          if (add) begin
            ld_en         = 1'b1;
            ld_idx        = cnt_r;
            ld_data.addr  = addr_r;
            ld_data.since = now_r;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
          ov_nxt    = 1'b1;
          okind_nxt = (func_r == FN_CHECK) ? KIND_VERDICT : KIND_AUTO;
          oaddr_nxt = addr_r;
          ocnt_nxt  = add ? cnt_r + CNT_W'(1) : cnt_r;
          olast_nxt = 1'b1;
        end
      end
      ST_SWEEP: begin
        odrop_nxt = 1'b0;
        ostat_nxt = ST_NOCHG;
        if (rem_r != '0) begin
          shift_all = 1'b1;
          rem_nxt   = rem_r - CNT_W'(1);
          if (expired) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            if (pend_v_r) begin
              ov_nxt    = 1'b1;
              okind_nxt = KIND_EXPIRED;
              oaddr_nxt = pend_addr_r;
              ocnt_nxt  = pend_cnt_r;
              olast_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_addr_nxt = head.addr;
            pend_cnt_nxt  = cnt_r - CNT_W'(1);
          end else begin
            ld_en = 1'b1;
          end
        end else begin
          ov_nxt     = 1'b1;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          if (pend_v_r) begin
            okind_nxt = KIND_EXPIRED;
            oaddr_nxt = pend_addr_r;
            ocnt_nxt  = pend_cnt_r;
          end else begin
            okind_nxt = KIND_EMPTY;
            oaddr_nxt = '0;
            ocnt_nxt  = cnt_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rem_r    <= '0;
      hit_r    <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      hit_r    <= hit_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    okind_r     <= okind_nxt;
    odrop_r     <= odrop_nxt;
    oaddr_r     <= oaddr_nxt;
    ostat_r     <= ostat_nxt;
    ocnt_r      <= ocnt_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kind           = okind_r;
  assign out_drop           = odrop_r;
  assign out_entry_addr_out = oaddr_r;
  assign out_status         = ostat_r;
  assign out_list_count     = ocnt_r;
  assign out_last           = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("entry count above capacity");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= cnt_r || state_r == ST_IDLE)
    else $error("pass longer than the list");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_VERDICT || out_kind == KIND_AUTO ||
                  out_kind == KIND_EMPTY) |-> out_last)
    else $error("single result beat without last");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func != FN_NONE |=> busy)
    else $error("command accepted but block not busy");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_EXPIRED && out_kind != KIND_EMPTY &&
    out_status == ST_ADDED |-> out_list_count == cnt_r && cnt_r != '0)
    else $error("added entry not counted");

endmodule

`default_nettype wire

// ===== sim/timed_address_blocklist_monitor.sv =====
// monitor for the timed address blocklist: mirrors the list, predicts and compares every result beat
`default_nettype none

module timed_address_blocklist_monitor
  import tab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [15:0] in_syn_ack_ratio,
  input  wire logic [31:0] in_now_time,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_kind,
  input  wire logic        out_drop,
  input  wire logic [31:0] out_entry_addr_out,
  input  wire logic [2:0]  out_status,
  input  wire logic [6:0]  out_list_count,
  input  wire logic        out_last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatches,
  output int               beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic        drop;
    logic [31:0] addr;
    logic [2:0]  status;
    logic [6:0]  count;
    logic        last;
  } beat_t;

  beat_t       expected_beats[$];
  logic [31:0] list_addr  [CAP];
  logic [31:0] list_since [CAP];
  int          list_len;
  logic [31:0] duration;
  logic [15:0] threshold;
  logic [31:0] allow_a;
  logic [31:0] allow_b;
  logic [31:0] allow_c;

  initial begin
    mismatches = 0;
    beats_due  = 0;
  end

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic beat_t make_beat(input logic [1:0] kind, input logic drop,
                                      input logic [31:0] addr, input logic [2:0] status,
                                      input logic last);
    beat_t b;
    b.kind   = kind;
    b.drop   = drop;
    b.addr   = addr;
    b.status = status;
    b.count  = 7'(list_len);
    b.last   = last;
    return b;
  endfunction

  function automatic bit is_allowed(input logic [31:0] a);
    return a == allow_a || a == allow_b || a == allow_c;
  endfunction

  function automatic bit is_listed(input logic [31:0] a);
    for (int i = 0; i < list_len; i++) begin
      if (list_addr[i] == a) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] try_add(input logic [31:0] a, input logic [31:0] t);
    if (list_len >= CAP) begin
      return ST_FULL;
    end
    if (is_listed(a)) begin
      return ST_LISTED;
    end
    list_addr[list_len]  = a;
    list_since[list_len] = t;
    list_len++;
    return ST_ADDED;
  endfunction

  // expired entries leave one by one, the rest close up in order
  task automatic sweep_list(input logic [31:0] now);
    beat_t       held;
    bit          have;
    int          i;
    int          j;
    logic [31:0] age;
    logic [31:0] gone;
    have = 1'b0;
    i = 0;
    while (i < list_len) begin
      age = now - list_since[i];
      if (age > duration) begin
        gone = list_addr[i];
        for (j = i; j + 1 < list_len; j++) begin
          list_addr[j]  = list_addr[j + 1];
          list_since[j] = list_since[j + 1];
        end
        list_len--;
        if (have) begin
          expected_beats.push_back(held);
        end
        held = make_beat(KIND_EXPIRED, 1'b0, gone, ST_NOCHG, 1'b0);
        have = 1'b1;
      end else begin
        i++;
      end
    end
    if (have) begin
      held.last = 1'b1;
      expected_beats.push_back(held);
    end else begin
      expected_beats.push_back(make_beat(KIND_EMPTY, 1'b0, 32'd0, ST_NOCHG, 1'b1));
    end
  endtask

  task automatic apply_command(input logic [1:0] f, input logic [31:0] a,
                               input logic [15:0] r, input logic [31:0] t);
    logic [2:0] st;
    logic       drp;
    case (f)
      FN_CHECK: begin
        drp = 1'b0;
        st  = ST_NOCHG;
        if (is_allowed(a)) begin
          st = ST_ALLOW;
        end else if (is_listed(a)) begin
          drp = 1'b1;
          st  = ST_LISTED;
        end else if (r > threshold) begin
          drp = 1'b1;
          st  = try_add(a, t);
        end
        expected_beats.push_back(make_beat(KIND_VERDICT, drp, a, st, 1'b1));
      end
      FN_AUTO: begin
        st = is_allowed(a) ? ST_ALLOW : try_add(a, t);
        expected_beats.push_back(make_beat(KIND_AUTO, 1'b0, a, st, 1'b1));
      end
      FN_SWEEP: begin
        sweep_list(t);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      expected_beats.delete();
      list_len  = 0;
      duration  = RST_DURATION;
      threshold = RST_THRESHOLD;
      allow_a   = RST_ALLOW_A;
      allow_b   = RST_ALLOW_B;
      allow_c   = RST_ALLOW_C;
    end else begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected beat kind %0d addr %h", out_kind, out_entry_addr_out));
        end else begin
          want = expected_beats.pop_front();
          if (out_kind !== want.kind)
            report($sformatf("kind got %0d want %0d", out_kind, want.kind));
          if (out_drop !== want.drop)
            report($sformatf("drop got %0d want %0d", out_drop, want.drop));
          if (out_entry_addr_out !== want.addr)
            report($sformatf("addr got %h want %h", out_entry_addr_out, want.addr));
          if (out_status !== want.status)
            report($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_list_count !== want.count)
            report($sformatf("list count got %0d want %0d", out_list_count, want.count));
          if (out_last !== want.last)
            report($sformatf("last got %0d want %0d", out_last, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DURATION:  duration  = cfg_data;
          CFG_THRESHOLD: threshold = cfg_data[15:0];
          CFG_ALLOW_A:   allow_a   = cfg_data;
          CFG_ALLOW_B:   allow_b   = cfg_data;
          CFG_ALLOW_C:   allow_c   = cfg_data;
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        apply_command(in_func, in_src_addr, in_syn_ack_ratio, in_now_time);
      end
    end
    beats_due <= expected_beats.size();
  end

endmodule

`default_nettype wire

// ===== sim/timed_address_blocklist_top_test.sv =====
// testbench top for the timed address blocklist: clock, reset, commands, settings and verdict
`default_nettype none

module timed_address_blocklist_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tab_pkg::*;

  localparam int SETTLE_CYCLES = CAP + 16;
  localparam int CYCLE_LIMIT   = 500000;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [1:0]  in_func          = FN_CHECK;
  logic [31:0] in_src_addr      = 32'd0;
  logic [15:0] in_syn_ack_ratio = 16'd0;
  logic [31:0] in_now_time      = 32'd0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic        out_drop;
  logic [31:0] out_entry_addr_out;
  logic [2:0]  out_status;
  logic [6:0]  out_list_count;
  logic        out_last;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index        = CFG_DURATION;
  logic [31:0] cfg_data         = 32'd0;
  int          mismatches;
  int          beats_due;
  int          cycle_count      = 0;

  logic [31:0] seen_addr[$];
  logic [31:0] time_base;
  logic [15:0] cur_threshold    = RST_THRESHOLD;
  logic [31:0] cur_allow_a      = RST_ALLOW_A;
  logic [31:0] cur_allow_b      = RST_ALLOW_B;
  logic [31:0] cur_allow_c      = RST_ALLOW_C;
  bit          gaps_on          = 1'b1;

  timed_address_blocklist_top dut (.*);

  timed_address_blocklist_monitor list_watch (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] f, input logic [31:0] a,
                          input logic [15:0] r, input logic [31:0] t);
    start            <= 1'b1;
    in_func          <= f;
    in_src_addr      <= a;
    in_syn_ack_ratio <= r;
    in_now_time      <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every predicted beat is back, then idle before the next step
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(input logic [31:0] dur, input logic [15:0] thr,
                                input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c);
    cfg_beat(CFG_DURATION, dur);
    cfg_beat(CFG_THRESHOLD, {16'd0, thr});
    cfg_beat(CFG_ALLOW_A, a);
    cfg_beat(CFG_ALLOW_B, b);
    cfg_beat(CFG_ALLOW_C, c);
    cfg_valid     <= 1'b0;
    cur_threshold = thr;
    cur_allow_a   = a;
    cur_allow_b   = b;
    cur_allow_c   = c;
  endtask

  task automatic random_cmd(input int sweep_pct, input int fresh_pct);
    logic [1:0]  f;
    logic [31:0] a;
    logic [15:0] r;
    logic [31:0] t;
    int          p;
    p = $urandom_range(0, 99);
    if (p < sweep_pct) begin
      f = FN_SWEEP;
    end else if (p < sweep_pct + 4) begin
      f = FN_NONE;
    end else if ($urandom_range(0, 1) == 0) begin
      f = FN_CHECK;
    end else begin
      f = FN_AUTO;
    end
    p = $urandom_range(0, 99);
    if (p < fresh_pct || seen_addr.size() == 0) begin
      a = $urandom;
      seen_addr.push_back(a);
      if (seen_addr.size() > 96) begin
        void'(seen_addr.pop_front());
      end
    end else if (p < fresh_pct + 8) begin
      case ($urandom_range(0, 2))
        0: a = cur_allow_a;
        1: a = cur_allow_b;
        default: a = cur_allow_c;
      endcase
    end else begin
      a = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
    end
    if ($urandom_range(0, 4) < 2) begin
      r = cur_threshold + 16'($urandom_range(0, 2)) - 16'd1;
    end else begin
      r = 16'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 9) == 0) begin
      t = $urandom;
    end else begin
      time_base = time_base + $urandom_range(0, 40);
      t = time_base;
    end
    send_cmd(f, a, r, t);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      pause($urandom_range(1, 15));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty sweep, whitelist, threshold edge, wrap of the age
    send_cmd(FN_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_cmd(FN_CHECK, RST_ALLOW_A, 16'hFFFF, 32'd0);
    send_cmd(FN_CHECK, 32'd0, 16'd0, 32'd0);
    send_cmd(FN_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_cmd(FN_CHECK, 32'hFFFF_FFFF, 16'd0, 32'd1);
    pause(3);
    send_cmd(FN_CHECK, 32'h0101_0101, RST_THRESHOLD, 32'd2);
    send_cmd(FN_CHECK, 32'h0101_0101, RST_THRESHOLD + 16'd1, 32'd100);
    send_cmd(FN_AUTO, RST_ALLOW_B, 16'd0, 32'd100);
    send_cmd(FN_AUTO, 32'h0202_0202, 16'd0, 32'd0);
    send_cmd(FN_AUTO, 32'h0202_0202, 16'd0, 32'd5);
    send_cmd(FN_CHECK, RST_ALLOW_C, 16'd0, 32'd6);
    send_cmd(FN_NONE, 32'h5A5A_A5A5, 16'h5555, 32'd7);
    send_cmd(FN_AUTO, 32'd0, 16'hAAAA, 32'd200);
    pause(1);
    send_cmd(FN_SWEEP, 32'd0, 16'd0, 32'd300);
    send_cmd(FN_SWEEP, 32'd0, 16'd0, 32'd301);
    send_cmd(FN_AUTO, 32'hDEAD_BEEF, 16'd0, 32'hFFFF_FFF0);
    send_cmd(FN_SWEEP, 32'd0, 16'd0, 32'd5);
    send_cmd(FN_CHECK, 32'hDEAD_BEEF, 16'd0, 32'd6);
    send_cmd(FN_NONE, 32'd0, 16'd0, 32'd6);
    send_cmd(FN_SWEEP, 32'd0, 16'd0, 32'hFFFF_FFFF);

    // default settings, ageing under way
    time_base = 32'd1000;
    for (int n = 0; n < 20; n++) begin
      random_cmd(15, 50);
      if (n == 10) begin
        settle();
      end
    end

    // nothing expires, every check above zero adds: fill the list and overrun it
    settle();
    write_settings(32'hFFFF_FFFF, 16'h0000, RST_ALLOW_A, RST_ALLOW_B, RST_ALLOW_C);
    for (int n = 0; n < 80; n++) begin
      random_cmd(2, 85);
    end

    // zero duration: a later sweep clears the full list in one go
    settle();
    write_settings(32'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, $urandom);
    time_base = time_base + 32'd1000;
    send_cmd(FN_SWEEP, 32'd0, 16'd0, time_base);
    for (int n = 0; n < 20; n++) begin
      random_cmd(25, 50);
    end

    // random settings, a listed address turned whitelisted, no idling at the end
    settle();
    write_settings($urandom_range(1, 400), 16'($urandom_range(0, 65535)), seen_addr[$],
                   $urandom, $urandom);
    for (int n = 0; n < 20; n++) begin
      if (n == 10) begin
        gaps_on = 1'b0;
      end
      random_cmd(15, 45);
    end

    settle();
    if (mismatches == 0 && beats_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
